### rtl/core/secant_root_finder_macros.svh
// Assertion macros used by the secant root finder controller
`ifndef SECANT_ROOT_FINDER_MACROS_SVH
`define SECANT_ROOT_FINDER_MACROS_SVH

// Antecedent implies consequent in the same cycle
`define SRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle
`define SRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/srf_pkg.sv
// Shared types and constants of the secant root finder
package srf_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int TOL_W     = 31;
  localparam int LIMIT_W   = 16;
  localparam int STATUS_W  = 2;
  localparam int REG_IDX_W = 3;

  // Register reset values
  localparam logic [TOL_W-1:0]          TOL_RESET   = TOL_W'(((1 << FRAC_BITS) + 500) / 1000);
  localparam logic [LIMIT_W-1:0]        LIMIT_RESET = LIMIT_W'(1000);
  localparam logic signed [DATA_W-1:0]  ONE_FIX     = DATA_W'(1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0]  NEG_ONE_FIX = -ONE_FIX;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_TOLERANCE   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ITER_LIMIT  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_SQ    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_LIN   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_COEFF_CONST = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND    = 2'd0,
    ST_LIMIT    = 2'd1,
    ST_ZERO_DEN = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SQ_MUL,
    OP_LIN_MUL,
    OP_QUAD_MUL,
    OP_POLY_SUM,
    OP_P_MUL,
    OP_Q_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_UPDATE,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e  op;
    logic    sel_x1;
    status_e status;
  } dp_cmd_t;

  typedef struct packed {
    logic f_equal;
    logic below_tol;
    logic limit_hit;
    logic div_last;
    logic out_busy;
  } dp_stat_t;

endpackage

### rtl/core/srf_if.sv
// Handshake channel interfaces: guesses in, results out, register writes
interface srf_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [srf_pkg::DATA_W-1:0] guess_first;
  logic signed [srf_pkg::DATA_W-1:0] guess_second;
  modport source (output valid, output guess_first, output guess_second, input ready);
  modport sink (input valid, input guess_first, input guess_second, output ready);
endinterface

interface srf_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [srf_pkg::DATA_W-1:0]  root;
  logic [srf_pkg::STATUS_W-1:0]       status;
  logic [srf_pkg::LIMIT_W-1:0]        steps_taken;
  modport source (output valid, output root, output status, output steps_taken, input ready);
  modport sink (input valid, input root, input status, input steps_taken, output ready);
endinterface

interface srf_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [srf_pkg::REG_IDX_W-1:0]      index;
  logic [srf_pkg::DATA_W-1:0]         data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/srf_dp.sv
// Datapath: registers, shared multiplier, restoring divider, result register
module srf_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  srf_pkg::dp_cmd_t                  cmd_i,
  output srf_pkg::dp_stat_t                 stat_o,
  input  logic signed [srf_pkg::DATA_W-1:0] guess_first_i,
  input  logic signed [srf_pkg::DATA_W-1:0] guess_second_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srf_pkg::REG_IDX_W-1:0]     cfg_index_i,
  input  logic [srf_pkg::DATA_W-1:0]        cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [srf_pkg::DATA_W-1:0] out_root_o,
  output logic [srf_pkg::STATUS_W-1:0]      out_status_o,
  output logic [srf_pkg::LIMIT_W-1:0]       out_steps_o
);
  localparam int DW  = srf_pkg::DATA_W;
  localparam int PW  = 2 * DW;                 // product width
  localparam int TW  = PW - srf_pkg::FRAC_BITS; // shifted product width
  localparam int SW  = TW + 2;                 // poly sum width
  localparam int NW  = PW + 1;                 // signed numerator width
  localparam int DDW = DW + 1;                 // signed denominator width
  localparam int RW  = DDW + 1;                // shifted remainder width
  localparam int CW  = $clog2(PW);
  localparam logic signed [DW-1:0] S_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic signed [DW-1:0] S_MIN = {1'b1, {(DW-1){1'b0}}};

  // Configuration registers
  logic [srf_pkg::TOL_W-1:0]   tol_q;
  logic [srf_pkg::LIMIT_W-1:0] limit_q;
  logic signed [DW-1:0]        c2_q, c1_q, c0_q;

  // Working registers
  logic signed [DW-1:0] x0_q, x1_q, f0_q, f1_q, sq_q;
  logic signed [PW-1:0] prod_q, prod_d, pp_q;
  logic signed [TW-1:0] acc_q;
  logic [srf_pkg::LIMIT_W-1:0] steps_q;

  // Divider registers
  logic [PW-1:0]  dvd_q;
  logic [RW-2:0]  rem_q;
  logic [DDW-1:0] dmag_q;
  logic [CW-1:0]  cnt_q;
  logic           qneg_q;

  // Result register
  logic                        out_valid_q;
  logic signed [DW-1:0]        out_root_q;
  logic [srf_pkg::STATUS_W-1:0] out_status_q;
  logic [srf_pkg::LIMIT_W-1:0] out_steps_q;

  logic signed [DW-1:0] px, mul_a, mul_b;
  logic signed [TW-1:0] prod_sh;
  logic signed [DW-1:0] sq_sat, sum_sat;
  logic signed [SW-1:0] sum;
  logic signed [NW-1:0] num;
  logic signed [DDW-1:0] den;
  logic [PW-1:0]  nmag;
  logic [DDW-1:0] dmag;
  logic [RW-1:0]  rem_sh, rem_sub;
  logic           rem_ge;
  logic signed [DW-1:0] x_next;
  logic [DW-1:0]  f1_abs;

  // Multiplier operand select
  assign px = cmd_i.sel_x1 ? x1_q : x0_q;
  always_comb begin
    mul_a = px;
    mul_b = px;
    unique case (cmd_i.op)
      srf_pkg::OP_LIN_MUL: begin
        mul_a = c1_q;
      end
      srf_pkg::OP_QUAD_MUL: begin
        mul_a = c2_q;
        mul_b = sq_q;
      end
      srf_pkg::OP_P_MUL: begin
        mul_a = x0_q;
        mul_b = f1_q;
      end
      srf_pkg::OP_Q_MUL: begin
        mul_a = x1_q;
        mul_b = f0_q;
      end
      default: begin
      end
    endcase
  end
  assign prod_d = PW'(mul_a) * PW'(mul_b);

  // Floor shift of the product, square saturation and polynomial sum
  assign prod_sh = TW'(prod_q >>> srf_pkg::FRAC_BITS);
  always_comb begin
    if (prod_sh > TW'(S_MAX)) sq_sat = S_MAX;
    else if (prod_sh < TW'(S_MIN)) sq_sat = S_MIN;
    else sq_sat = prod_sh[DW-1:0];
  end
  assign sum = SW'(acc_q) + SW'(prod_sh) + SW'(c0_q);
  always_comb begin
    if (sum > SW'(S_MAX)) sum_sat = S_MAX;
    else if (sum < SW'(S_MIN)) sum_sat = S_MIN;
    else sum_sat = sum[DW-1:0];
  end

  // Secant numerator and denominator magnitudes
  assign num  = NW'(pp_q) - NW'(prod_q);
  assign nmag = num[NW-1] ? PW'(-num) : PW'(num);
  assign den  = DDW'(f1_q) - DDW'(f0_q);
  assign dmag = den[DDW-1] ? DDW'(-den) : DDW'(den);

  // One restoring division step
  assign rem_sh  = {rem_q, dvd_q[PW-1]};
  assign rem_ge  = rem_sh >= RW'(dmag_q);
  assign rem_sub = rem_sh - RW'(dmag_q);

  // Quotient sign and saturation
  always_comb begin
    if (qneg_q) begin
      if (dvd_q >= PW'(64'h8000_0000)) x_next = S_MIN;
      else x_next = -$signed(dvd_q[DW-1:0]);
    end else begin
      if (dvd_q > PW'(S_MAX)) x_next = S_MAX;
      else x_next = $signed(dvd_q[DW-1:0]);
    end
  end

  assign f1_abs = f1_q[DW-1] ? DW'(-f1_q) : DW'(f1_q);

  // Status to the controller
  assign stat_o.f_equal   = f0_q == f1_q;
  assign stat_o.below_tol = f1_abs < DW'(tol_q);
  assign stat_o.limit_hit = steps_q >= limit_q;
  assign stat_o.div_last  = cnt_q == CW'(PW - 1);
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  // Configuration registers
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q   <= srf_pkg::TOL_RESET;
      limit_q <= srf_pkg::LIMIT_RESET;
      c2_q    <= srf_pkg::ONE_FIX;
      c1_q    <= srf_pkg::NEG_ONE_FIX;
      c0_q    <= srf_pkg::NEG_ONE_FIX;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        srf_pkg::REG_TOLERANCE:   tol_q   <= cfg_data_i[srf_pkg::TOL_W-1:0];
        srf_pkg::REG_ITER_LIMIT:  limit_q <= cfg_data_i[srf_pkg::LIMIT_W-1:0];
        srf_pkg::REG_COEFF_SQ:    c2_q    <= $signed(cfg_data_i);
        srf_pkg::REG_COEFF_LIN:   c1_q    <= $signed(cfg_data_i);
        srf_pkg::REG_COEFF_CONST: c0_q    <= $signed(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // Working registers, executed one command per cycle
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      srf_pkg::OP_LOAD: begin
        x0_q <= guess_first_i;
        x1_q <= guess_second_i;
      end
      srf_pkg::OP_SQ_MUL: prod_q <= prod_d;
      srf_pkg::OP_LIN_MUL: begin
        sq_q   <= sq_sat;
        prod_q <= prod_d;
      end
      srf_pkg::OP_QUAD_MUL: begin
        acc_q  <= prod_sh;
        prod_q <= prod_d;
      end
      srf_pkg::OP_POLY_SUM: begin
        if (cmd_i.sel_x1) f1_q <= sum_sat;
        else f0_q <= sum_sat;
      end
      srf_pkg::OP_P_MUL: prod_q <= prod_d;
      srf_pkg::OP_Q_MUL: begin
        pp_q   <= prod_q;
        prod_q <= prod_d;
      end
      srf_pkg::OP_DIV_INIT: begin
        dvd_q  <= nmag;
        dmag_q <= dmag;
        rem_q  <= '0;
        qneg_q <= num[NW-1] ^ den[DDW-1];
      end
      srf_pkg::OP_DIV_STEP: begin
        dvd_q <= {dvd_q[PW-2:0], rem_ge};
        rem_q <= rem_ge ? rem_sub[RW-2:0] : rem_sh[RW-2:0];
      end
      srf_pkg::OP_UPDATE: begin
        x0_q <= x1_q;
        f0_q <= f1_q;
        x1_q <= x_next;
      end
      default: begin
      end
    endcase
  end

  // Step and divider counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= '0;
      cnt_q   <= '0;
    end else begin
      if (cmd_i.op == srf_pkg::OP_LOAD) steps_q <= '0;
      else if (cmd_i.op == srf_pkg::OP_UPDATE) steps_q <= steps_q + 1'b1;
      if (cmd_i.op == srf_pkg::OP_DIV_INIT) cnt_q <= '0;
      else if (cmd_i.op == srf_pkg::OP_DIV_STEP) cnt_q <= cnt_q + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == srf_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == srf_pkg::OP_EMIT) begin
      out_root_q   <= x1_q;
      out_status_q <= cmd_i.status;
      out_steps_q  <= steps_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_root_o   = out_root_q;
  assign out_status_o = out_status_q;
  assign out_steps_o  = out_steps_q;
endmodule

### rtl/core/srf_ctrl.sv
// Controller: sequences polynomial evaluation, checks, secant division and result
`include "secant_root_finder_macros.svh"
module srf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output srf_pkg::dp_cmd_t  cmd_o,
  input  srf_pkg::dp_stat_t stat_i
);
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_SQ       = 4'd1;
  localparam logic [3:0] S_LIN      = 4'd2;
  localparam logic [3:0] S_QUAD     = 4'd3;
  localparam logic [3:0] S_SUM      = 4'd4;
  localparam logic [3:0] S_INIT_CHK = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_PMUL     = 4'd7;
  localparam logic [3:0] S_QMUL     = 4'd8;
  localparam logic [3:0] S_DINIT    = 4'd9;
  localparam logic [3:0] S_DSTEP    = 4'd10;
  localparam logic [3:0] S_UPD      = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0]       state_q, state_d;
  logic             psel_q, psel_d;
  logic             init_q, init_d;
  srf_pkg::status_e status_q, status_d;

  assign in_ready_o = state_q == S_IDLE;

  // Next state and command
  always_comb begin
    state_d       = state_q;
    psel_d        = psel_q;
    init_d        = init_q;
    status_d      = status_q;
    cmd_o.op      = srf_pkg::OP_IDLE;
    cmd_o.sel_x1  = psel_q;
    cmd_o.status  = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = srf_pkg::OP_LOAD;
          state_d  = S_SQ;
          psel_d   = 1'b0;
          init_d   = 1'b1;
        end
      end
      S_SQ: begin
        cmd_o.op = srf_pkg::OP_SQ_MUL;
        state_d  = S_LIN;
      end
      S_LIN: begin
        cmd_o.op = srf_pkg::OP_LIN_MUL;
        state_d  = S_QUAD;
      end
      S_QUAD: begin
        cmd_o.op = srf_pkg::OP_QUAD_MUL;
        state_d  = S_SUM;
      end
      S_SUM: begin
        cmd_o.op = srf_pkg::OP_POLY_SUM;
        if (!psel_q) begin
          psel_d  = 1'b1;
          state_d = S_SQ;
        end else begin
          state_d = init_q ? S_INIT_CHK : S_CHECK;
        end
      end
      S_INIT_CHK: begin
        if (stat_i.f_equal) begin
          status_d = srf_pkg::ST_ZERO_DEN;
          state_d  = S_EMIT;
        end else begin
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (stat_i.limit_hit) begin
          status_d = srf_pkg::ST_LIMIT;
          state_d  = S_EMIT;
        end else if (stat_i.below_tol) begin
          status_d = srf_pkg::ST_FOUND;
          state_d  = S_EMIT;
        end else if (stat_i.f_equal) begin
          status_d = srf_pkg::ST_ZERO_DEN;
          state_d  = S_EMIT;
        end else begin
          state_d = S_PMUL;
        end
      end
      S_PMUL: begin
        cmd_o.op = srf_pkg::OP_P_MUL;
        state_d  = S_QMUL;
      end
      S_QMUL: begin
        cmd_o.op = srf_pkg::OP_Q_MUL;
        state_d  = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.op = srf_pkg::OP_DIV_INIT;
        state_d  = S_DSTEP;
      end
      S_DSTEP: begin
        cmd_o.op = srf_pkg::OP_DIV_STEP;
        if (stat_i.div_last) state_d = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = srf_pkg::OP_UPDATE;
        psel_d   = 1'b1;
        init_d   = 1'b0;
        state_d  = S_SQ;
      end
      S_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.op = srf_pkg::OP_EMIT;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      psel_q   <= 1'b0;
      init_q   <= 1'b0;
      status_q <= srf_pkg::ST_LIMIT;
    end else begin
      state_q  <= state_d;
      psel_q   <= psel_d;
      init_q   <= init_d;
      status_q <= status_d;
    end
  end

  `SRF_ASSERT_NXT(a_load_starts_x0, in_valid_i && in_ready_o, (state_q == S_SQ) && !psel_q && init_q, "request did not start evaluation of the first guess")
  `SRF_ASSERT_NXT(a_div_to_update, (state_q == S_DSTEP) && stat_i.div_last, state_q == S_UPD, "divider end did not lead to update")
  `SRF_ASSERT_IMP(a_emit_free, cmd_o.op == srf_pkg::OP_EMIT, !stat_i.out_busy, "result emitted over a pending one")
endmodule

### rtl/core/secant_root_finder.sv
// Top level of the secant root finder: controller, datapath and channel hookup
//
//  channel | dir | payload                              | accepted when
//  in_i    | in  | guess_first, guess_second            | valid && ready
//  out_o   | out | root, status, steps_taken            | valid && ready
//  cfg_i   | in  | index, data (register write)         | valid && ready
//
// After a request is accepted, both guesses are evaluated and the first checks run;
// each secant step then forms the two products, runs the bit-serial divider, updates
// the guesses, evaluates f(x1) and checks; finally the result is loaded.
// The 64-step restoring divider sets the per-step cost.
// Reset leaves the block idle with default registers; no clearing pass.
// A result waits in the output register; a stalled sink holds the next finish.
module secant_root_finder (
  input  logic       clk_i,
  input  logic       rst_ni,
  srf_in_if.sink     in_i,
  srf_out_if.source  out_o,
  srf_cfg_if.sink    cfg_i
);
  srf_pkg::dp_cmd_t  cmd;
  srf_pkg::dp_stat_t stat;

  srf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  srf_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .guess_first_i  (in_i.guess_first),
    .guess_second_i (in_i.guess_second),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_ready_o    (cfg_i.ready),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .out_root_o     (out_o.root),
    .out_status_o   (out_o.status),
    .out_steps_o    (out_o.steps_taken)
  );
endmodule
